### design/ssm_pkg.sv
// Shared constants, codes and types of the shift-and string matcher.
package ssm_pkg;

   localparam int PATTERN_MAX = 512;
   localparam int WORD_BITS   = 64;
   localparam int NWORDS      = (PATTERN_MAX + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int STEP_W      = WORD_IDX_W + 1;
   localparam int OFF_W       = $clog2(WORD_BITS);
   localparam int ALPHABET    = 256;
   localparam int CHAR_W      = 8;
   localparam int POS_W       = 9;
   localparam int LEN_W       = 10;
   localparam int CNT_W       = 32;
   localparam int ADDR_W      = CHAR_W + WORD_IDX_W;
   localparam int FUNC_W      = 2;
   localparam int REQ_DATA_W  = ((CHAR_W + POS_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_TEXT    = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_RESTART = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   // Per-cycle commands from the sequencer to the active-vector shifter.
   typedef struct packed {
      logic                  clear;
      logic                  start;
      logic                  step;
      logic [WORD_IDX_W-1:0] widx;
   } vec_ctl_type;

endpackage

### design/shift_and_string_matcher.sv
// Top level of the shift-and exact string matcher.
//
// Usage: each request transaction carries a selector in req_tuser and a
// character and pattern position in req_tdata. Selector 0 loads a pattern
// character, 1 feeds a text byte, 2 clears the mask table and the search
// state, 3 restarts the search keeping the table. Every request yields one
// response transaction: rsp_tuser is the match flag, rsp_tdata the count of
// text bytes since the last reset, clear or restart, saturating at all ones.
// csr_we with csr_wdata sets the pattern length; write it only while idle.
//
// Load and text requests walk the NWORDS words of the state vector and the
// table row through the single read port of the mask memory, one word per
// cycle, then wait in a finish state until the output register is free.
// Clear and restart go from acceptance straight to the finish state.
// One request is worked on at a time; the next one is accepted while the
// previous response still waits in the output register, and the block holds
// its finished result when the receiver stalls.
// Reset clears the search state, the byte count and the row valid bits at
// once (no clearing pass) and sets the pattern length to one.
module shift_and_string_matcher
   import ssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_value [7:0], pattern_position [16:8]
   input  logic [FUNC_W-1:0]     req_tuser,  // func [1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CNT_W-1:0]      rsp_tdata,  // text_count [31:0]
   output logic                  rsp_tuser,  // match [0]
   input  logic                  csr_we,
   input  logic [LEN_W-1:0]      csr_wdata
);

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   vec_ctl_type          vec_ctl;
   logic [WORD_BITS-1:0] vec_mask;
   logic [LEN_W-1:0]     pattern_length;
   logic                 hit;

   ssm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .vec_ctl        (vec_ctl),
      .vec_mask       (vec_mask),
      .pattern_length (pattern_length),
      .hit            (hit)
   );

   ssm_mask_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ssm_vector u_vector (
      .clock          (clock),
      .reset          (reset),
      .ctl            (vec_ctl),
      .mask           (vec_mask),
      .pattern_length (pattern_length),
      .hit            (hit)
   );

endmodule

### design/ssm_mask_ram.sv
// Character mask table: one write port and one registered read port.
module ssm_mask_ram
   import ssm_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mask_mem [ALPHABET*NWORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mask_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mask_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ssm_vector.sv
// Active state vector held as a ring of words, advanced one word per cycle while stepped.
module ssm_vector
   import ssm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  vec_ctl_type          ctl,
   input  logic [WORD_BITS-1:0] mask,
   input  logic [LEN_W-1:0]     pattern_length,
   output logic                 hit
);

   logic [WORD_BITS-1:0] av_ff [NWORDS];
   logic [WORD_BITS-1:0] nxt;
   logic                 carry_ff;
   logic                 hit_ff;
   logic [LEN_W-1:0]     len_sat;
   logic [LEN_W-1:0]     bit_idx;
   logic                 at_word;

   always_comb begin
      len_sat = (32'(pattern_length) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : pattern_length;
      bit_idx = len_sat - 1'b1;
      at_word = (len_sat != '0) && (32'(ctl.widx) == 32'(bit_idx >> OFF_W));
      nxt     = {av_ff[0][WORD_BITS-2:0], carry_ff} & mask;
   end

   // The word at the head of the ring is the one being advanced; the result
   // re-enters at the tail, so after NWORDS steps the ring is back in order.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < NWORDS; i++) begin
            av_ff[i] <= '0;
         end
      end else if (ctl.step) begin
         for (int i = 0; i < NWORDS - 1; i++) begin
            av_ff[i] <= av_ff[i+1];
         end
         av_ff[NWORDS-1] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b1;
         hit_ff   <= 1'b0;
      end else if (ctl.start) begin
         carry_ff <= 1'b1;
         hit_ff   <= 1'b0;
      end else if (ctl.step) begin
         carry_ff <= av_ff[0][WORD_BITS-1];
         if (at_word) begin
            hit_ff <= nxt[bit_idx[OFF_W-1:0]];
         end
      end
   end

   assign hit = hit_ff;

endmodule

### design/ssm_ctrl.sv
// Sequencer: request latch, word walk, table writes, byte counter and result register.
module ssm_ctrl
   import ssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CNT_W-1:0]      rsp_tdata,
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [LEN_W-1:0]      csr_wdata,
   output logic                  ram_wr_en,
   output logic [ADDR_W-1:0]     ram_wr_addr,
   output logic [WORD_BITS-1:0]  ram_wr_data,
   output logic                  ram_rd_en,
   output logic [ADDR_W-1:0]     ram_rd_addr,
   input  logic [WORD_BITS-1:0]  ram_rd_data,
   output vec_ctl_type           vec_ctl,
   output logic [WORD_BITS-1:0]  vec_mask,
   output logic [LEN_W-1:0]      pattern_length,
   input  logic                  hit
);

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  proc_ff, proc_in;
   logic [WORD_IDX_W-1:0] pidx_ff, pidx_in;
   func_type              func_ff, func_in;
   logic [CHAR_W-1:0]     ch_ff, ch_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ALPHABET-1:0]   row_valid_ff, row_valid_in;
   logic [LEN_W-1:0]      len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_match_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  accept;
   logic                  issue;
   logic                  rsp_free;
   logic                  rsp_load;
   func_type              req_func;
   logic [WORD_BITS-1:0]  gated;
   logic [WORD_BITS-1:0]  bit_word;

   assign req_func   = func_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_RUN) && (32'(cnt_ff) < NWORDS);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_FIN) && rsp_free;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      row_valid_in = row_valid_ff;
      proc_in      = issue;
      pidx_in      = cnt_ff[WORD_IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_func;
               ch_in   = req_tdata[CHAR_W-1:0];
               pos_in  = req_tdata[CHAR_W+POS_W-1:CHAR_W];
               cnt_in  = '0;
               case (req_func)
                  FUNC_LOAD: begin
                     state_in = ST_RUN;
                  end
                  FUNC_TEXT: begin
                     state_in = ST_RUN;
                     count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
                  end
                  FUNC_CLEAR: begin
                     state_in     = ST_FIN;
                     row_valid_in = '0;
                     count_in     = '0;
                  end
                  default: begin
                     state_in = ST_FIN;
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == NWORDS) begin
               state_in = ST_FIN;
               // The row now holds real data in every word.
               if (func_ff == FUNC_LOAD) begin
                  row_valid_in[ch_ff] = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         proc_ff      <= 1'b0;
         count_ff     <= '0;
         row_valid_ff <= '0;
         len_ff       <= LEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         proc_ff      <= proc_in;
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      func_ff <= func_in;
      ch_ff   <= ch_in;
      pos_ff  <= pos_in;
      if (rsp_load) begin
         rsp_match_ff <= hit;
         rsp_count_ff <= count_ff;
      end
   end

   // A row never loaded since the last clear reads as all zeros.
   assign gated = row_valid_ff[ch_ff] ? ram_rd_data : '0;

   always_comb begin
      bit_word = '0;
      if ((32'(pos_ff) < PATTERN_MAX) && (pidx_ff == WORD_IDX_W'(pos_ff >> OFF_W))) begin
         bit_word = WORD_BITS'(1) << pos_ff[OFF_W-1:0];
      end
   end

   assign ram_rd_en   = issue;
   assign ram_rd_addr = {ch_ff, cnt_ff[WORD_IDX_W-1:0]};
   assign ram_wr_en   = proc_ff && (func_ff == FUNC_LOAD);
   assign ram_wr_addr = {ch_ff, pidx_ff};
   assign ram_wr_data = gated | bit_word;

   assign vec_ctl.clear = accept && ((req_func == FUNC_CLEAR) || (req_func == FUNC_RESTART));
   assign vec_ctl.start = accept;
   assign vec_ctl.step  = proc_ff && (func_ff == FUNC_TEXT);
   assign vec_ctl.widx  = pidx_ff;
   assign vec_mask       = gated;
   assign pattern_length = len_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_match_ff;

endmodule

### design/ssm_checker.sv
// Port-level assertions for the string matcher and the bind that attaches them.
module ssm_checker
   import ssm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [CNT_W-1:0]      rsp_tdata,
   input logic                  rsp_tuser
);

   // Only one request transaction is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // A match can only come from a text byte, which makes the count nonzero.
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata != '0))
      else $error("match reported with zero byte count");

endmodule

bind shift_and_string_matcher ssm_checker u_ssm_checker (.*);

### verif/tb.sv
// Self-checking testbench for the shift-and string matcher.
`timescale 1ns / 1ps

module tb;
   import ssm_pkg::*;

   localparam int unsigned MODE1_AT = 150;
   localparam int unsigned MODE2_AT = 300;
   localparam int unsigned HOLD_AT  = 320;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned FILL_LEN = WORD_BITS + 8;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] count;
   } match_report_type;

   typedef struct packed {
      logic             set_len;
      logic [LEN_W-1:0] len_value;
      func_type         func;
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0] pos;
      logic             typed;
      logic             exp_hit;
      logic [CNT_W-1:0] exp_count;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // char_value [7:0], pattern_position [16:8]
   logic [FUNC_W-1:0]     req_tuser;   // func [1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [CNT_W-1:0]      rsp_tdata;   // text_count [31:0]
   logic                  rsp_tuser;   // match [0]
   logic                  csr_we;
   logic [LEN_W-1:0]      csr_wdata;

   // Mirror of the matcher state.
   logic [PATTERN_MAX-1:0] mask_rows [ALPHABET];
   logic [PATTERN_MAX-1:0] state_vec;
   logic [CNT_W-1:0]       text_seen;
   logic [LEN_W-1:0]       len_reg;

   match_report_type pending_reports [$];
   int unsigned fail_count = 0;
   int unsigned sent_total = 0;
   int unsigned send_idle_pct = 7;
   int unsigned recv_stall_pct = 50;

   // Expected values are typed in only for the opening rows after reset.
   stim_row_type directed_rows [25] = '{
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h61, 9'd0,   1'b1, 1'b0, 32'd1},
      '{1'b0, 10'd0,    FUNC_LOAD,    8'h00, 9'd0,   1'b1, 1'b0, 32'd1},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h00, 9'h1FF, 1'b1, 1'b1, 32'd2},
      '{1'b0, 10'd0,    FUNC_RESTART, 8'hFF, 9'd0,   1'b1, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h00, 9'd0,   1'b1, 1'b1, 32'd1},
      '{1'b0, 10'd0,    FUNC_CLEAR,   8'h00, 9'd0,   1'b1, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h00, 9'd0,   1'b1, 1'b0, 32'd1},
      '{1'b1, 10'd2,    FUNC_LOAD,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_LOAD,    8'h01, 9'd1,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_LOAD,    8'hFF, 9'h1FF, 1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_RESTART, 8'h00, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h01, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h01, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_LOAD,    8'h02, 9'd1,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_LOAD,    8'h01, 9'd1,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h02, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b1, 10'd0,    FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h01, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b1, 10'h3FF,  FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'h01, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b1, 10'd512,  FUNC_RESTART, 8'h00, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0},
      '{1'b1, 10'd1,    FUNC_TEXT,    8'hFF, 9'd0,   1'b0, 1'b0, 32'd0}
   };

   shift_and_string_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $time, what);
      end
   endfunction

   function automatic match_report_type advance_matcher(input func_type op,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [POS_W-1:0] pos);
      match_report_type r;
      int unsigned eff;
      r.hit = 1'b0;
      case (op)
         FUNC_LOAD: begin
            mask_rows[ch][pos] = 1'b1;
         end
         FUNC_TEXT: begin
            state_vec = {state_vec[PATTERN_MAX-2:0], 1'b1} & mask_rows[ch];
            if (text_seen != '1) begin
               text_seen++;
            end
            eff = (len_reg > PATTERN_MAX) ? PATTERN_MAX : len_reg;
            if (eff != 0) begin
               r.hit = state_vec[eff-1];
            end
         end
         FUNC_CLEAR: begin
            foreach (mask_rows[i]) begin
               mask_rows[i] = '0;
            end
            state_vec = '0;
            text_seen = '0;
         end
         default: begin
            state_vec = '0;
            text_seen = '0;
         end
      endcase
      r.count = text_seen;
      return r;
   endfunction

   task automatic send_item(input func_type op, input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0] pos, input bit typed = 1'b0,
                            input logic typed_hit = 1'b0,
                            input logic [CNT_W-1:0] typed_count = '0);
      match_report_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({pos, ch});
      do @(posedge clock); while (!req_tready);
      predicted = advance_matcher(op, ch, pos);
      if (typed) begin
         predicted.hit   = typed_hit;
         predicted.count = typed_count;
      end
      pending_reports.push_back(predicted);
      sent_total++;
      if (sent_total == MODE1_AT) begin
         send_idle_pct  = 50;
         recv_stall_pct = 7;
      end else if (sent_total == MODE2_AT) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   endtask

   // The length register may only change once every transaction has drained.
   task automatic write_length(input logic [LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we  <= 1'b0;
      len_reg = value;
   endtask

   task automatic run_search_phase(input int unsigned limit);
      logic [CHAR_W-1:0] letters [3];
      logic [CHAR_W-1:0] pattern [$];
      logic [LEN_W-1:0]  length;
      int unsigned       plen;
      int unsigned       n_text;
      int unsigned       pick;
      foreach (letters[j]) begin
         letters[j] = CHAR_W'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         length = LEN_W'($urandom_range(1, 6));
      end else if (pick == 5) begin
         length = LEN_W'($urandom_range(7, 20));
      end else if (pick == 6) begin
         // Lengths on both sides of a state word boundary, some carrying across it.
         length = LEN_W'($urandom_range(60, 70));
      end else if (pick == 7) begin
         length = '0;
      end else if (pick == 8) begin
         length = LEN_W'($urandom_range(PATTERN_MAX + 1, 1023));
      end else begin
         length = LEN_W'($urandom_range(1, 3));
      end
      plen = (length == 0 || length > PATTERN_MAX) ? $urandom_range(1, 6) : length;
      write_length(length);
      send_item(($urandom_range(0, 3) != 0) ? FUNC_CLEAR : FUNC_RESTART,
                CHAR_W'($urandom), POS_W'($urandom));
      for (int i = 0; i < plen; i++) begin
         pattern.push_back(letters[$urandom_range(0, 2)]);
         send_item(FUNC_LOAD, pattern[i], POS_W'(i));
      end
      n_text = (plen > 20) ? $urandom_range(4, 8) : $urandom_range(10, 30);
      for (int i = 0; (i < n_text) && (sent_total < limit); i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            foreach (pattern[k]) begin
               send_item(FUNC_TEXT, pattern[k], POS_W'($urandom));
            end
         end else if (pick < 29) begin
            send_item(FUNC_RESTART, CHAR_W'($urandom), POS_W'($urandom));
         end else if (pick < 33) begin
            send_item(FUNC_LOAD, CHAR_W'($urandom), POS_W'($urandom));
         end else if (pick < 38) begin
            send_item(FUNC_TEXT, CHAR_W'($urandom), POS_W'($urandom));
         end else begin
            send_item(FUNC_TEXT, letters[$urandom_range(0, 2)], POS_W'($urandom));
         end
      end
   endtask

   task automatic run_random_until(input int unsigned limit);
      while (sent_total < limit) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat (20) begin
               send_item(func_type'($urandom_range(0, 3)), CHAR_W'($urandom),
                         POS_W'($urandom));
            end
         end else begin
            run_search_phase(limit);
         end
      end
   endtask

   // A single character loaded at the first FILL_LEN positions, then a run of it
   // long enough to carry the match across a state word boundary, first at that
   // length and then with a length above the maximum, broken once by another byte.
   task automatic run_long_pattern_phase();
      logic [CHAR_W-1:0] fill;
      fill = CHAR_W'($urandom);
      write_length(LEN_W'(FILL_LEN));
      send_item(FUNC_CLEAR, fill, '0);
      for (int i = 0; i < FILL_LEN; i++) begin
         send_item(FUNC_LOAD, fill, POS_W'(i));
      end
      repeat (FILL_LEN + 3) begin
         send_item(FUNC_TEXT, fill, POS_W'($urandom));
      end
      write_length('1);
      repeat (3) begin
         send_item(FUNC_TEXT, fill, POS_W'($urandom));
      end
      send_item(FUNC_TEXT, fill + 8'd1, POS_W'($urandom));
      send_item(FUNC_TEXT, fill, POS_W'($urandom));
   endtask

   // Response side: random stalls, plus one long hold-off to back up the block.
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && (sent_total >= HOLD_AT)) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      match_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected response: match %0b count %0d",
                                   rsp_tuser, rsp_tdata));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tuser !== want.hit || rsp_tdata !== want.count) begin
               note_failure($sformatf(
                  "response mismatch: expected match %0b count %0d, got match %0b count %0d",
                  want.hit, want.count, rsp_tuser, rsp_tdata));
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_LOAD;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      len_reg    = LEN_W'(1);
      void'(advance_matcher(FUNC_CLEAR, '0, '0));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_len) begin
            write_length(directed_rows[i].len_value);
         end
         send_item(directed_rows[i].func, directed_rows[i].ch, directed_rows[i].pos,
                   directed_rows[i].typed, directed_rows[i].exp_hit,
                   directed_rows[i].exp_count);
      end

      run_random_until(150);
      run_long_pattern_phase();
      run_random_until(450);

      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (4 * (NWORDS + 3)) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
design/ssm_pkg.sv
design/ssm_mask_ram.sv
design/ssm_vector.sv
design/ssm_ctrl.sv
design/shift_and_string_matcher.sv
design/ssm_checker.sv
verif/tb.sv
